// File: hdl/tile_animation_table_core_macros.svh
// Assertion macros for the tile animation table core.
// Included by the top level; the macros refer to its clk and rst_n.
`ifndef TILE_ANIMATION_TABLE_CORE_MACROS_SVH
`define TILE_ANIMATION_TABLE_CORE_MACROS_SVH

// Check that a condition implies another in the same cycle
`define ATBL_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that a condition implies another in the next cycle
`define ATBL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/atbl_pkg.sv
// Shared types and constants of the tile animation table core.
// No dependencies; used by the controller, datapath, divider and top level.
package atbl_pkg;

    localparam int IN_W   = 96;
    localparam int OUT_W  = 48;
    localparam int CFG_W  = 15;
    localparam int SHW    = 9;
    localparam int OFF_W  = 16;

    localparam logic [25:0] WAIT_RST     = 26'd250000;
    localparam logic [14:0] WIDTH_RST    = 15'd256;
    localparam logic [8:0]  COUNT_RST    = 9'd64;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_BAD_TILE = 2'd1;
    localparam logic [1:0] ST_FULL     = 2'd2;

    localparam logic REG_SHEET_WIDTH = 1'b0;
    localparam logic REG_TILE_COUNT  = 1'b1;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_STEP   = 3'd1,
        CMD_WAIT   = 3'd2,
        CMD_ADD    = 3'd3,
        CMD_REWIND = 3'd4,
        CMD_READ   = 3'd5
    } cmd_code_t;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_CLR,
        DP_LOAD,
        DP_RD_REC,
        DP_EXEC,
        DP_TICK_EVAL,
        DP_STEP_WB,
        DP_DUR_EVAL,
        DP_SHOW_WB,
        DP_NEXT_TILE,
        DP_RESULT
    } dp_op_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic      clr_done;
        cmd_code_t cmd;
        logic      bad;
        logic      cnt_zero;
        logic      sweep_last;
        logic      is_frame;
        logic      need_step;
        logic      dur_hit;
        logic      div_done;
    } dp_stat_t;

endpackage

// File: hdl/atbl_div.sv
// Restoring divider, one quotient bit per cycle, for the sheet position.
// Depends on atbl_pkg.
module atbl_div (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic [atbl_pkg::OFF_W-1:0]  dividend,
    input  logic [14:0]                 divisor,
    output logic [atbl_pkg::OFF_W-1:0]  quotient,
    output logic [14:0]                 remainder,
    output logic                        done
);
    import atbl_pkg::*;

    localparam int CNT_W = $clog2(OFF_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [14:0]      rem_reg;
    logic [OFF_W-1:0] quo_reg;
    logic [14:0]      dvs_reg;
    logic [15:0]      shifted;
    logic             ge;

    // Trial subtract of the divisor from the shifted partial remainder
    assign shifted = {rem_reg, quo_reg[OFF_W-1]};
    assign ge      = shifted >= {1'b0, dvs_reg};

    // Sequence control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(OFF_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and quotient
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            quo_reg <= dividend;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            rem_reg <= ge ? 15'(shifted - {1'b0, dvs_reg}) : 15'(shifted);
            quo_reg <= {quo_reg[OFF_W-2:0], ge};
        end
    end

    assign quotient  = quo_reg;
    assign remainder = rem_reg;
    assign done      = done_reg;

endmodule

// File: hdl/atbl_dp.sv
// Datapath: tile table memories, frame memory, config registers and result.
// Depends on atbl_pkg and atbl_div.
module atbl_dp #(
    parameter int NUM_TILES   = 256,
    parameter int MAX_FRAMES  = 32,
    parameter int TILE_WIDTH  = 32,
    parameter int TILE_HEIGHT = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  atbl_pkg::dp_cmd_t           cmd,
    output atbl_pkg::dp_stat_t          stat,
    input  logic [atbl_pkg::IN_W-1:0]   in_data,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [atbl_pkg::CFG_W-1:0]  cfg_data,
    output logic [atbl_pkg::OUT_W-1:0]  out_data
);
    import atbl_pkg::*;

    localparam int IW     = $clog2(NUM_TILES);
    localparam int PW     = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
    localparam int NW     = $clog2(MAX_FRAMES + 1);
    localparam int FDEPTH = NUM_TILES * MAX_FRAMES;
    localparam int FAW    = $clog2(FDEPTH);

    // Per-tile table, one memory per field (record fields share an address), and frame lists
    logic [SHW-1:0] shown_mem [NUM_TILES];
    logic [25:0]    wait_mem  [NUM_TILES];
    logic [31:0]    el_mem    [NUM_TILES];
    logic [PW-1:0]  pos_mem   [NUM_TILES];
    logic [NW-1:0]  fnum_mem  [NUM_TILES];
    logic [8:0]     step_mem  [NUM_TILES];
    logic [7:0]     shows_mem [FDEPTH];
    logic [25:0]    dur_mem   [FDEPTH];

    // Registered read data
    logic [SHW-1:0] shown_q;
    logic [25:0]    wait_q;
    logic [31:0]    el_q;
    logic [PW-1:0]  pos_q;
    logic [NW-1:0]  fnum_q;
    logic [8:0]     step_q;
    logic [7:0]     shows_q;
    logic [25:0]    dur_q;

    // Control and configuration registers
    logic [14:0]    width_reg;
    logic [8:0]     count_cfg_reg;
    logic [IW-1:0]  idx_reg;
    logic [1:0]     status_reg;

    // Item payload registers
    cmd_code_t      cmd_reg;
    logic [7:0]     tile_reg;
    logic [8:0]     step_in_reg;
    logic [15:0]    wait_in_reg;
    logic [7:0]     ftile_reg;
    logic [25:0]    dur_in_reg;
    logic [19:0]    dt_reg;
    logic [31:0]    el_reg;
    logic [PW-1:0]  pos_reg;
    logic [OUT_W-1:0] out_reg;

    // Combinational values
    logic [8:0]     count;
    logic           bad;
    logic           full;
    logic [IW-1:0]  tile_addr;
    logic [IW-1:0]  sel_addr;
    logic [IW-1:0]  rec_raddr;
    logic [IW-1:0]  wr_addr;
    logic [FAW-1:0] fbase;
    logic [FAW-1:0] f_raddr;
    logic [32:0]    el_sum;
    logic [31:0]    el_new;
    logic [PW-1:0]  pos_eff;
    logic [PW-1:0]  pos_wrap;
    logic [31:0]    pos_inc;
    logic signed [10:0] nxt;
    logic           nxt_ok;
    logic           classic_skip;
    logic           need_step;
    logic           dur_hit;
    logic           rd_rec;
    logic           rd_frame;

    logic           we_shown, we_wait, we_el, we_pos, we_fnum, we_step, we_frame;
    logic [SHW-1:0] d_shown;
    logic [25:0]    d_wait;
    logic [31:0]    d_el;
    logic [PW-1:0]  d_pos;
    logic [NW-1:0]  d_fnum;
    logic [8:0]     d_step;

    logic           div_start;
    logic [OFF_W-1:0] div_quo;
    logic [14:0]    div_rem;
    logic           div_done;
    logic [OFF_W-1:0] offset;
    logic [14:0]    divisor;
    logic [15:0]    sy;

    // Effective tile count and address selection
    assign count     = (32'(count_cfg_reg) < NUM_TILES) ? count_cfg_reg : 9'(NUM_TILES);
    assign bad       = (cmd_reg == CMD_STEP || cmd_reg == CMD_WAIT || cmd_reg == CMD_ADD ||
                        cmd_reg == CMD_REWIND || cmd_reg == CMD_READ) &&
                       (32'(tile_reg) >= 32'(count));
    assign full      = 32'(fnum_q) >= MAX_FRAMES;
    assign tile_addr = IW'(tile_reg);
    assign sel_addr  = (cmd_reg == CMD_TICK) ? idx_reg : tile_addr;
    assign rec_raddr = (cmd.op == DP_NEXT_TILE) ? idx_reg + 1'b1 : sel_addr;
    assign wr_addr   = (cmd.op == DP_CLR) ? idx_reg : sel_addr;
    assign fbase     = FAW'(sel_addr) * FAW'(MAX_FRAMES);

    // Tick arithmetic: saturating elapsed time, frame position handling
    assign el_sum    = {1'b0, el_q} + 33'(dt_reg);
    assign el_new    = el_sum[32] ? '1 : el_sum[31:0];
    assign pos_eff   = (32'(pos_q) >= 32'(fnum_q)) ? '0 : pos_q;
    assign pos_inc   = 32'(pos_reg) + 32'd1;
    assign pos_wrap  = (pos_inc >= 32'(fnum_q)) ? '0 : PW'(pos_inc);
    assign f_raddr   = fbase + ((cmd.op == DP_TICK_EVAL) ? FAW'(pos_eff) : FAW'(pos_wrap));
    assign classic_skip = 32'(shown_q) >= 32'(count);
    assign need_step = (fnum_q == '0) && !classic_skip && (el_new >= {6'd0, wait_q});
    assign dur_hit   = el_reg >= {6'd0, dur_q};
    assign nxt       = $signed({2'b00, shown_q}) + $signed({{2{step_q[8]}}, step_q});
    assign nxt_ok    = !nxt[10] && (nxt[9:0] < {1'b0, count});

    assign rd_rec    = (cmd.op == DP_RD_REC) || (cmd.op == DP_NEXT_TILE);
    assign rd_frame  = (cmd.op == DP_TICK_EVAL) || (cmd.op == DP_DUR_EVAL);

    // Decode write enables and data per datapath operation
    always_comb
    begin
        we_shown = 1'b0; we_wait = 1'b0; we_el = 1'b0; we_pos = 1'b0;
        we_fnum  = 1'b0; we_step = 1'b0; we_frame = 1'b0;
        d_shown  = shown_q;
        d_wait   = WAIT_RST;
        d_el     = '0;
        d_pos    = '0;
        d_fnum   = fnum_q + 1'b1;
        d_step   = step_in_reg;
        div_start = 1'b0;
        case (cmd.op)
            DP_CLR:
            begin
                we_shown = 1'b1; we_wait = 1'b1; we_el = 1'b1; we_pos = 1'b1;
                we_fnum  = 1'b1; we_step = 1'b1;
                d_shown  = SHW'(idx_reg) & SHW'(8'hFF);
                d_fnum   = '0;
                d_step   = '0;
            end
            DP_EXEC:
            begin
                case (cmd_reg)
                    CMD_STEP:   we_step = 1'b1;
                    CMD_WAIT:
                    begin
                        we_wait = 1'b1;
                        d_wait  = 26'(32'(wait_in_reg) * 32'd1000);
                    end
                    CMD_ADD:
                    begin
                        we_frame = !full;
                        we_fnum  = !full;
                    end
                    CMD_REWIND:
                    begin
                        we_shown = 1'b1;
                        we_pos   = 1'b1;
                        d_shown  = SHW'(tile_reg);
                    end
                    CMD_READ:   div_start = 1'b1;
                    default:    ;
                endcase
            end
            DP_TICK_EVAL:
            begin
                we_el = (fnum_q == '0) && !classic_skip && !need_step;
                d_el  = el_new;
            end
            DP_STEP_WB:
            begin
                we_el    = 1'b1;
                we_shown = nxt_ok;
                d_shown  = nxt[SHW-1:0];
            end
            DP_DUR_EVAL:
            begin
                we_el  = !dur_hit;
                we_pos = !dur_hit;
                d_el   = el_reg;
                d_pos  = pos_reg;
            end
            DP_SHOW_WB:
            begin
                we_el    = 1'b1;
                we_pos   = 1'b1;
                d_pos    = pos_reg;
                we_shown = 32'(shows_q) < 32'(count);
                d_shown  = {1'b0, shows_q};
            end
            default: ;
        endcase
    end

    // Tile table memories
    always_ff @(posedge clk)
    begin
        if (we_shown) shown_mem[wr_addr] <= d_shown;
        if (we_wait)  wait_mem[wr_addr]  <= d_wait;
        if (we_el)    el_mem[wr_addr]    <= d_el;
        if (we_pos)   pos_mem[wr_addr]   <= d_pos;
        if (we_fnum)  fnum_mem[wr_addr]  <= d_fnum;
        if (rd_rec)
        begin
            shown_q <= shown_mem[rec_raddr];
            wait_q  <= wait_mem[rec_raddr];
            el_q    <= el_mem[rec_raddr];
            pos_q   <= pos_mem[rec_raddr];
            fnum_q  <= fnum_mem[rec_raddr];
        end
    end

    // Step memory, read at the shown index of the tile
    always_ff @(posedge clk)
    begin
        if (we_step) step_mem[wr_addr] <= d_step;
        if (cmd.op == DP_TICK_EVAL) step_q <= step_mem[IW'(shown_q)];
    end

    // Frame list memory
    always_ff @(posedge clk)
    begin
        if (we_frame)
        begin
            shows_mem[fbase + FAW'(fnum_q)] <= ftile_reg;
            dur_mem[fbase + FAW'(fnum_q)]   <= dur_in_reg;
        end
        if (rd_frame)
        begin
            shows_q <= shows_mem[f_raddr];
            dur_q   <= dur_mem[f_raddr];
        end
    end

    // Configuration, sweep index and status
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg     <= WIDTH_RST;
            count_cfg_reg <= COUNT_RST;
            idx_reg       <= '0;
            status_reg    <= ST_OK;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_SHEET_WIDTH: width_reg     <= cfg_data;
                    REG_TILE_COUNT:  count_cfg_reg <= cfg_data[8:0];
                endcase
            end
            case (cmd.op)
                DP_CLR, DP_NEXT_TILE: idx_reg <= idx_reg + 1'b1;
                DP_LOAD:
                begin
                    idx_reg    <= '0;
                    status_reg <= ST_OK;
                end
                DP_EXEC:
                    if (cmd_reg == CMD_ADD && full) status_reg <= ST_FULL;
                default: ;
            endcase
        end
    end

    // Read result arithmetic
    assign offset  = OFF_W'(32'(shown_q) * 32'(TILE_WIDTH));
    assign divisor = (width_reg == '0) ? 15'd1 : width_reg;
    assign sy      = 16'(32'(div_quo) * 32'(TILE_HEIGHT));

    atbl_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (offset),
        .divisor   (divisor),
        .quotient  (div_quo),
        .remainder (div_rem),
        .done      (div_done)
    );

    // Latch the item, carry tick values, form the result
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            DP_LOAD:
            begin
                cmd_reg     <= cmd_code_t'(in_data[2:0]);
                tile_reg    <= in_data[10:3];
                step_in_reg <= in_data[19:11];
                wait_in_reg <= in_data[35:20];
                ftile_reg   <= in_data[43:36];
                dur_in_reg  <= in_data[69:44];
                dt_reg      <= in_data[89:70];
            end
            DP_TICK_EVAL:
            begin
                el_reg  <= el_new;
                pos_reg <= pos_eff;
            end
            DP_DUR_EVAL: pos_reg <= pos_wrap;
            DP_RESULT:
            begin
                if (bad)
                    out_reg <= {(OUT_W - 2)'(0), ST_BAD_TILE};
                else if (cmd_reg == CMD_READ)
                    out_reg <= {2'b00, 6'(fnum_q), sy, div_rem[13:0], shown_q[7:0], status_reg};
                else
                    out_reg <= {(OUT_W - 2)'(0), status_reg};
            end
            default: ;
        endcase
    end

    assign out_data = out_reg;

    // Status toward the controller
    always_comb
    begin
        stat.clr_done   = idx_reg == IW'(NUM_TILES - 1);
        stat.cmd        = cmd_reg;
        stat.bad        = bad;
        stat.cnt_zero   = count == '0;
        stat.sweep_last = (32'(idx_reg) + 32'd1) >= 32'(count);
        stat.is_frame   = fnum_q != '0;
        stat.need_step  = need_step;
        stat.dur_hit    = dur_hit;
        stat.div_done   = div_done;
    end

endmodule

// File: hdl/atbl_ctrl.sv
// Controller state machine: table clear, command sequencing, tick sweep.
// Depends on atbl_pkg.
module atbl_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    output logic                out_valid,
    input  logic                out_ready,
    input  atbl_pkg::dp_stat_t  stat,
    output atbl_pkg::dp_cmd_t   cmd
);
    import atbl_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR, S_IDLE, S_DECODE, S_EXEC, S_DIV,
        S_T_EVAL, S_T_STEP, S_T_DUR, S_T_SHOW, S_T_NEXT, S_DONE
    } state_t;

    state_t state_reg;
    logic   out_valid_reg;
    logic   out_free;

    assign in_ready  = state_reg == S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Datapath operation for the current state
    always_comb
    begin
        cmd.op = DP_NOP;
        unique case (state_reg)
            S_CLEAR:  cmd.op = DP_CLR;
            S_IDLE:   if (in_valid) cmd.op = DP_LOAD;
            S_DECODE:
            begin
                if (stat.cmd == CMD_TICK)
                begin
                    if (!stat.cnt_zero) cmd.op = DP_RD_REC;
                end
                else if (!stat.bad)
                    cmd.op = DP_RD_REC;
            end
            S_EXEC:   cmd.op = DP_EXEC;
            S_DIV:    cmd.op = DP_NOP;
            S_T_EVAL: cmd.op = DP_TICK_EVAL;
            S_T_STEP: cmd.op = DP_STEP_WB;
            S_T_DUR:  cmd.op = DP_DUR_EVAL;
            S_T_SHOW: cmd.op = DP_SHOW_WB;
            S_T_NEXT: if (!stat.sweep_last) cmd.op = DP_NEXT_TILE;
            S_DONE:   if (out_free) cmd.op = DP_RESULT;
        endcase
    end

    // State and output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (state_reg == S_DONE && out_free)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                S_CLEAR:  if (stat.clr_done) state_reg <= S_IDLE;
                S_IDLE:   if (in_valid) state_reg <= S_DECODE;
                S_DECODE:
                begin
                    case (stat.cmd) inside
                        CMD_TICK:
                            state_reg <= stat.cnt_zero ? S_DONE : S_T_EVAL;
                        CMD_STEP, CMD_WAIT, CMD_ADD, CMD_REWIND, CMD_READ:
                            state_reg <= stat.bad ? S_DONE : S_EXEC;
                        default:
                            state_reg <= S_DONE;
                    endcase
                end
                S_EXEC:   state_reg <= (stat.cmd == CMD_READ) ? S_DIV : S_DONE;
                S_DIV:    if (stat.div_done) state_reg <= S_DONE;
                S_T_EVAL:
                begin
                    if (stat.is_frame)
                        state_reg <= S_T_DUR;
                    else if (stat.need_step)
                        state_reg <= S_T_STEP;
                    else
                        state_reg <= S_T_NEXT;
                end
                S_T_STEP: state_reg <= S_T_NEXT;
                S_T_DUR:  state_reg <= stat.dur_hit ? S_T_SHOW : S_T_NEXT;
                S_T_SHOW: state_reg <= S_T_NEXT;
                S_T_NEXT: state_reg <= stat.sweep_last ? S_DONE : S_T_EVAL;
                S_DONE:   if (out_free) state_reg <= S_IDLE;
            endcase
        end
    end

endmodule

// File: hdl/tile_animation_table_core.sv
// Channel   Dir  Payload (low bit first)
// s_axis    in   command, tile_number, step_offset, wait_ms, frame_tile, duration_us, dt_us
// m_axis    out  status, shown_tile, sheet_x, sheet_y, frame_total
// cfg       in   0 sheet_width, 1 tile_count
//
// After reset every entry of the table is cleared before the first item is taken.
// One item at a time: set step / set wait / add frame / rewind go through accept,
// decode, execute and result; a bad tile or spare command skips execute.
// Read also waits on the bit-serial divider between execute and result.
// A tick sweeps every valid tile (evaluate, then a step or frame write-back,
// then advance) before its result.
// A result waits in the output register while the next item is taken in.
// Top level of the tile animation table; depends on atbl_pkg, atbl_ctrl, atbl_dp.
`include "tile_animation_table_core_macros.svh"

module tile_animation_table_core #(
    parameter int NUM_TILES   = 256,
    parameter int MAX_FRAMES  = 32,
    parameter int TILE_WIDTH  = 32,
    parameter int TILE_HEIGHT = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    // command[2:0], tile_number[10:3], step_offset[19:11], wait_ms[35:20],
    // frame_tile[43:36], duration_us[69:44], dt_us[89:70], zero fill to 96
    input  logic [atbl_pkg::IN_W-1:0]   s_axis_tdata,
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    // status[1:0], shown_tile[9:2], sheet_x[23:10], sheet_y[39:24],
    // frame_total[45:40], zero fill to 48
    output logic [atbl_pkg::OUT_W-1:0]  m_axis_tdata,
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [atbl_pkg::CFG_W-1:0]  cfg_data
);
    import atbl_pkg::*;

    dp_cmd_t  dp_cmd;
    dp_stat_t dp_stat;

    atbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .stat      (dp_stat),
        .cmd       (dp_cmd)
    );

    atbl_dp #(
        .NUM_TILES   (NUM_TILES),
        .MAX_FRAMES  (MAX_FRAMES),
        .TILE_WIDTH  (TILE_WIDTH),
        .TILE_HEIGHT (TILE_HEIGHT)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (dp_cmd),
        .stat      (dp_stat),
        .in_data   (s_axis_tdata),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_data  (m_axis_tdata)
    );

    // A result load never overwrites an item still waiting at the output
    `ATBL_ASSERT_SAME(a_no_overwrite, dp_cmd.op == DP_RESULT, !m_axis_tvalid || m_axis_tready, "result overwrote pending item")
    // One item in work at a time
    `ATBL_ASSERT_NEXT(a_one_item, s_axis_tvalid && s_axis_tready, !s_axis_tready, "second item taken while busy")
    // A taken result with no new one behind it leaves the output empty
    `ATBL_ASSERT_NEXT(a_out_drain, m_axis_tvalid && m_axis_tready && dp_cmd.op != DP_RESULT, !m_axis_tvalid, "output item repeated")

endmodule
